// ===== hw/rtl/m4mul_pkg.sv =====
package m4mul_pkg;

    localparam int DIM         = 4;
    localparam int FRAC_BITS   = 16;
    localparam int ELEM_W      = 32;
    localparam int COL_W       = $clog2(DIM);
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int SUM_W       = PROD_W + 2;
    localparam int LANE_STAGES = 4;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef t_elem [DIM-1:0]          t_vec;
    // indexed [column][row]
    typedef t_vec  [DIM-1:0]          t_mat;

    localparam t_elem Q_ONE   = t_elem'(ELEM_W'(1) << FRAC_BITS);
    localparam t_elem ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam t_elem ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_MUL  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [COL_W-1:0] column_index;
        t_elem            elem_row0;
        t_elem            elem_row1;
        t_elem            elem_row2;
        t_elem            elem_row3;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0] out_column;
        t_elem            res_row0;
        t_elem            res_row1;
        t_elem            res_row2;
        t_elem            res_row3;
        logic             saturated;
    } t_out_item;

    // pipeline tag that travels beside the lanes
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
    } t_tag;

    function automatic t_mat ident_mat();
        t_mat m;
        for (int c = 0; c < DIM; c++) begin
            for (int r = 0; r < DIM; r++) begin
                m[c][r] = (c == r) ? Q_ONE : t_elem'(0);
            end
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/matrix4_column_major_multiply.sv =====
// 4x4 column-major matrix product engine, signed Q16.16.
// Input channel (i_valid / o_stall / i_item): a load transfer writes one
// column of the stored left matrix L; a multiply transfer brings column c
// of a right matrix R and yields column c of L*R.
// Output channel (o_valid / i_stall / o_item): one result per multiply,
// nothing per load. Each element is a full-precision dot product shifted
// right by 16 bits (toward minus infinity) and clipped to 32 bits;
// saturated reports a clip in any row.
// Throughput: one item per cycle while not stalled. Four lanes, one per result row, each run
// four 32x32 multipliers followed by an add tree.
// Pipeline: a multiply transfer loads the product registers, then pair sum,
// total, clip and output register follow in that order. A load is visible
// to a multiply in the very next cycle.
// Reset: L returns to identity and the pipeline empties.
// Stall: while the output register holds a result and i_stall is high the
// whole pipeline freezes and o_stall is raised; nothing is lost.
module matrix4_column_major_multiply (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  m4mul_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output m4mul_pkg::t_out_item o_item
);
    import m4mul_pkg::*;

    logic  w_adv;
    logic  w_in_acc;
    t_vec  w_rcol;
    t_mat  w_mat;
    t_vec  w_res;
    logic [DIM-1:0] w_clip;
    t_tag  r_tag [LANE_STAGES];

    assign o_stall  = !w_adv;
    assign w_in_acc = i_valid && w_adv;

    assign w_rcol[0] = i_item.elem_row0;
    assign w_rcol[1] = i_item.elem_row1;
    assign w_rcol[2] = i_item.elem_row2;
    assign w_rcol[3] = i_item.elem_row3;

    m4mul_lmat u_lmat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (w_in_acc && (i_item.cmd == CMD_LOAD)),
        .i_col      (i_item.column_index),
        .i_col_data (w_rcol),
        .o_mat      (w_mat)
    );

    // one lane per result row
    for (genvar r = 0; r < DIM; r++) begin : g_lane
        t_vec w_lrow;

        for (genvar k = 0; k < DIM; k++) begin : g_row
            assign w_lrow[k] = w_mat[k][r];
        end

        m4mul_lane u_lane (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_lrow (w_lrow),
            .i_rcol (w_rcol),
            .o_res  (w_res[r]),
            .o_clip (w_clip[r])
        );
    end

    // carry valid and column index alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_STAGES; s++) begin
                r_tag[s] <= '0;
            end
        end else if (w_adv) begin
            r_tag[0].valid <= w_in_acc && (i_item.cmd == CMD_MUL);
            r_tag[0].col   <= i_item.column_index;
            for (int s = 1; s < LANE_STAGES; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    m4mul_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stall (i_stall),
        .i_tag   (r_tag[LANE_STAGES-1]),
        .i_res   (w_res),
        .i_clip  (w_clip),
        .o_adv   (w_adv),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_item.cmd == CMD_LOAD) |=> !r_tag[0].valid)
        else $error("load transfer entered the result pipeline");

endmodule

// ===== hw/rtl/m4mul_lmat.sv =====
module m4mul_lmat (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [m4mul_pkg::COL_W-1:0] i_col,
    input  m4mul_pkg::t_vec         i_col_data,
    output m4mul_pkg::t_mat         o_mat
);
    import m4mul_pkg::*;

    t_mat r_mat;

    // write one column per load transfer; reset to identity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= ident_mat();
        end else if (i_we) begin
            r_mat[i_col] <= i_col_data;
        end
    end

    assign o_mat = r_mat;

    a_reset_identity: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_mat == ident_mat()))
        else $error("left matrix not identity after reset");

endmodule

// ===== hw/rtl/m4mul_lane.sv =====
module m4mul_lane (
    input  logic            i_clk,
    input  logic            i_adv,
    input  m4mul_pkg::t_vec i_lrow,
    input  m4mul_pkg::t_vec i_rcol,
    output m4mul_pkg::t_elem o_res,
    output logic            o_clip
);
    import m4mul_pkg::*;

    localparam int HI_LSB = FRAC_BITS + ELEM_W - 1;

    logic signed [PROD_W-1:0] r_prod [DIM];
    logic signed [PAIR_W-1:0] r_pair [DIM/2];
    logic signed [SUM_W-1:0]  r_sum;
    t_elem                    r_res;
    logic                     r_clip;

    logic [SUM_W-1-HI_LSB:0]  w_hi;
    logic                     w_fits;

    // stage 1: four products of row and column
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < DIM; k++) begin
                r_prod[k] <= PROD_W'($signed(i_lrow[k])) * PROD_W'($signed(i_rcol[k]));
            end
        end
    end

    // stage 2: pair sums
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int j = 0; j < DIM/2; j++) begin
                r_pair[j] <= PAIR_W'(r_prod[2*j]) + PAIR_W'(r_prod[2*j+1]);
            end
        end
    end

    // stage 3: full dot product
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum <= SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
        end
    end

    // stage 4: drop fraction bits and clip to element range
    assign w_hi   = r_sum[SUM_W-1:HI_LSB];
    assign w_fits = (&w_hi) || !(|w_hi);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (w_fits) begin
                r_res <= r_sum[HI_LSB:FRAC_BITS];
            end else if (r_sum[SUM_W-1]) begin
                r_res <= ELEM_MIN;
            end else begin
                r_res <= ELEM_MAX;
            end
            r_clip <= !w_fits;
        end
    end

    assign o_res  = r_res;
    assign o_clip = r_clip;

    a_clip_value: assert property (@(posedge i_clk)
        r_clip |-> (r_res == ELEM_MAX || r_res == ELEM_MIN))
        else $error("clipped lane result not at a range limit");

endmodule

// ===== hw/rtl/m4mul_merge.sv =====
module m4mul_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_stall,
    input  m4mul_pkg::t_tag      i_tag,
    input  m4mul_pkg::t_vec      i_res,
    input  logic [m4mul_pkg::DIM-1:0] i_clip,
    output logic                 o_adv,
    output logic                 o_valid,
    output m4mul_pkg::t_out_item o_item
);
    import m4mul_pkg::*;

    logic      r_out_valid;
    t_out_item r_out_item;

    // pipeline moves whenever the output register is free or being drained
    assign o_adv = !r_out_valid || !i_stall;

    // hold valid until transfer; load new column result on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= i_tag.valid;
        end
    end

    // combine the lane results into one column
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_out_item.out_column <= i_tag.col;
            r_out_item.res_row0   <= i_res[0];
            r_out_item.res_row1   <= i_res[1];
            r_out_item.res_row2   <= i_res[2];
            r_out_item.res_row3   <= i_res[3];
            r_out_item.saturated  <= |i_clip;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.saturated) |->
            (r_out_item.res_row0 == ELEM_MAX || r_out_item.res_row0 == ELEM_MIN ||
             r_out_item.res_row1 == ELEM_MAX || r_out_item.res_row1 == ELEM_MIN ||
             r_out_item.res_row2 == ELEM_MAX || r_out_item.res_row2 == ELEM_MIN ||
             r_out_item.res_row3 == ELEM_MAX || r_out_item.res_row3 == ELEM_MIN))
        else $error("saturated flag without a clipped element");

endmodule
